// File: src/swms_pkg.sv
// Shared types and constants for the sliding-window minimum-sum block.
// Used by every module under src; depends on nothing.
package swms_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COUNT_BITS   = 20;
  localparam int CFG_BITS     = 11;
  localparam int SUM_OUT_BITS = 26;
  localparam int DELTA_BITS   = SAMPLE_BITS + 1;

  // Work queue between the front and the back end
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_OUT_BITS-1:0] min_sum;
    logic [COUNT_BITS-1:0]          best_start;
    logic                           too_short;
  } out_item_t;

  // One classified sample on its way to the accumulator
  typedef struct packed {
    logic signed [DELTA_BITS-1:0] delta;      // new sample minus the one leaving the window
    logic                         fill;       // window not yet complete
    logic                         first_full; // this sample completes the first window
    logic                         last;
    logic                         is_short;   // stream ends before one full window
    logic [COUNT_BITS-1:0]        start;      // start index of the window ending here
  } work_t;

endpackage

// File: src/swms_front.sv
// Front end: accepts samples, keeps the delay line and the sample counter,
// and classifies each sample into a work_t entry. Depends on swms_pkg.
module swms_front #(
  parameter int WINDOW_MAX = 1024,
  parameter int LEN_W      = 11,
  parameter int POS_W      = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic [LEN_W-1:0]   len,
  input  logic               in_valid,
  output logic               in_ready,
  input  swms_pkg::in_item_t in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output swms_pkg::work_t    push_data
);

  localparam int CMP_W = (LEN_W > swms_pkg::COUNT_BITS) ? LEN_W + 1 : swms_pkg::COUNT_BITS + 1;

  logic [POS_W-1:0]                    pos;
  logic [POS_W-1:0]                    pos_next;
  logic [LEN_W-1:0]                    pos_inc;
  logic [swms_pkg::COUNT_BITS-1:0]     count;
  logic [swms_pkg::COUNT_BITS-1:0]     count_next;
  logic [CMP_W-1:0]                    idx_c;
  logic [CMP_W-1:0]                    len_c;
  logic                                accept;

  logic signed [swms_pkg::SAMPLE_BITS-1:0] mem [WINDOW_MAX];
  logic signed [swms_pkg::SAMPLE_BITS-1:0] rdata;

  logic                                    s1_valid;
  logic signed [swms_pkg::SAMPLE_BITS-1:0] s1_sample;
  logic                                    s1_fill;
  logic                                    s1_first;
  logic                                    s1_last;
  logic                                    s1_short;
  logic [swms_pkg::COUNT_BITS-1:0]         s1_start;

  assign in_ready = !s1_valid || push_ready;
  assign accept   = in_valid && in_ready;

  // Advance the circular write position and the saturating counter
  always_comb begin
    pos_inc    = LEN_W'(pos) + LEN_W'(1);
    pos_next   = (pos_inc >= len) ? '0 : POS_W'(pos_inc);
    count_next = (count == '1) ? count : count + 1'b1;
    idx_c      = CMP_W'(count);
    len_c      = CMP_W'(len);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pos   <= '0;
      count <= '0;
    end else if (accept) begin
      if (in_data.is_last) begin
        pos   <= '0;
        count <= '0;
      end else begin
        pos   <= pos_next;
        count <= count_next;
      end
    end
  end

  // Delay line: read the leaving sample and write the new one at one address
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata    <= mem[pos];
      mem[pos] <= in_data.sample;
    end
  end

  // Classification stage
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= in_data.sample;
      s1_fill   <= idx_c < len_c;
      s1_first  <= idx_c == len_c - CMP_W'(1);
      s1_last   <= in_data.is_last;
      s1_short  <= CMP_W'(count_next) < len_c;
      s1_start  <= swms_pkg::COUNT_BITS'(idx_c - len_c + CMP_W'(1));
    end
  end

  // Hand the entry to the queue; rdata holds while the stage is stalled
  always_comb begin
    push_valid           = s1_valid;
    push_data.delta      = s1_fill ? swms_pkg::DELTA_BITS'(s1_sample)
                         : swms_pkg::DELTA_BITS'(s1_sample) - swms_pkg::DELTA_BITS'(rdata);
    push_data.fill       = s1_fill;
    push_data.first_full = s1_first;
    push_data.last       = s1_last;
    push_data.is_short   = s1_short;
    push_data.start      = s1_start;
  end

endmodule

// File: src/swms_fifo.sv
// Short work queue between front and back end, QUEUE_DEPTH entries of work_t.
// Depends on swms_pkg.
module swms_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            push_valid,
  output logic            push_ready,
  input  swms_pkg::work_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output swms_pkg::work_t pop_data
);

  swms_pkg::work_t                entries [swms_pkg::QUEUE_DEPTH];
  logic [swms_pkg::QPTR_W-1:0]    wr_ptr;
  logic [swms_pkg::QPTR_W-1:0]    rd_ptr;
  logic [swms_pkg::QPTR_W:0]      fill;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = fill != (swms_pkg::QPTR_W + 1)'(swms_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Track pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: src/swms_back.sv
// Back end: running window sum, best-sum tracking and the result register.
// Depends on swms_pkg.
module swms_back #(
  parameter int SUM_W = 27
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  swms_pkg::work_t     pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output swms_pkg::out_item_t out_data
);

  logic signed [SUM_W-1:0]         sum;
  logic signed [SUM_W-1:0]         sum_next;
  logic signed [SUM_W-1:0]         best;
  logic signed [SUM_W-1:0]         best_next;
  logic [swms_pkg::COUNT_BITS-1:0] bidx;
  logic [swms_pkg::COUNT_BITS-1:0] bidx_next;
  logic                            pop;

  assign pop_ready = !pop_data.last || !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;

  // Update the window sum and keep the later window on ties
  always_comb begin
    sum_next  = sum + SUM_W'(pop_data.delta);
    best_next = best;
    bidx_next = bidx;
    if (pop_data.fill) begin
      if (pop_data.first_full) begin
        best_next = sum_next;
        bidx_next = '0;
      end
    end else if (sum_next <= best) begin
      best_next = sum_next;
      bidx_next = pop_data.start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sum  <= '0;
      best <= '0;
      bidx <= '0;
    end else if (pop) begin
      if (pop_data.last) begin
        sum  <= '0;
        best <= '0;
        bidx <= '0;
      end else begin
        sum  <= sum_next;
        best <= best_next;
        bidx <= bidx_next;
      end
    end
  end

  // Result register: load on the last sample, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && pop_data.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_data.last) begin
      out_data.min_sum    <= pop_data.is_short ? swms_pkg::SUM_OUT_BITS'(sum_next)
                                               : swms_pkg::SUM_OUT_BITS'(best_next);
      out_data.best_start <= pop_data.is_short ? '0 : bidx_next;
      out_data.too_short  <= pop_data.is_short;
    end
  end

endmodule

// File: src/sliding_window_min_sum.sv
// Top level of the sliding-window minimum-sum block: window length register,
// front end, work queue and back end. Depends on swms_pkg and the swms_* modules.
//
// Takes one signed sample per cycle while the queue has room: the front end
// reads the leaving sample and writes the new one at the same address of a
// single-port delay line (WINDOW_MAX entries) in the accept cycle, and the
// back end does one add and one compare per sample. The result of a stream
// passes through the classification stage and the queue before the result
// register loads, and stays until taken; the input keeps flowing while a
// result waits, until the queue fills.
// Writing window_len resets the stream in progress; write it only while idle.
// Values of 0 act as 1 and values above WINDOW_MAX act as WINDOW_MAX.
module sliding_window_min_sum #(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  swms_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output swms_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swms_pkg::CFG_BITS-1:0]   cfg_data
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int POS_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W = swms_pkg::SAMPLE_BITS + LEN_W + 1;

  logic [LEN_W-1:0] len;
  logic             clear;
  logic             push_valid;
  logic             push_ready;
  swms_pkg::work_t  push_data;
  logic             pop_valid;
  logic             pop_ready;
  swms_pkg::work_t  pop_data;

  assign cfg_ready = 1'b1;
  assign clear     = cfg_valid && cfg_ready;

  // Hold the effective window length, clamped into range
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_W'(1);
    end else if (clear) begin
      if (cfg_data == '0) begin
        len <= LEN_W'(1);
      end else if (int'(cfg_data) > WINDOW_MAX) begin
        len <= LEN_W'(WINDOW_MAX);
      end else begin
        len <= LEN_W'(cfg_data);
      end
    end
  end

  swms_front #(
    .WINDOW_MAX (WINDOW_MAX),
    .LEN_W      (LEN_W),
    .POS_W      (POS_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .len        (len),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  swms_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  swms_back #(
    .SUM_W (SUM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clear     (clear),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: src/swms_checker.sv
// Port-level checks for sliding_window_min_sum, bound to the top level.
// Depends on swms_pkg.
module swms_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input swms_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input swms_pkg::out_item_t out_data
);

  logic [3:0] pending;
  logic       last_in;
  logic       res_out;

  assign last_in = in_valid && in_ready && in_data.is_last;
  assign res_out = out_valid && out_ready;

  // Count streams ended but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (last_in && !res_out) begin
      pending <= pending + 1'b1;
    end else if (res_out && !last_in && pending != '0) begin
      pending <= pending - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_short_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.too_short |-> out_data.best_start == '0)
    else $error("short stream reports a nonzero start");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    res_out |-> pending != '0)
    else $error("result delivered without a finished stream");

endmodule

bind sliding_window_min_sum swms_checker u_swms_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: dv/tb_sliding_window_min_sum.sv
// Testbench for sliding_window_min_sum: drives sample streams, checks each result against a
// minimum window sum predictor or a typed want. Depends on swms_pkg and the RTL under src.
module tb_sliding_window_min_sum;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_DEPTH = 1024;
  localparam int unsigned COUNT_MAX = (1 << swms_pkg::COUNT_BITS) - 1;
  localparam int RANDOM_ITEMS = 460;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;
  typedef enum logic [2:0] {STYLE_WIDE, STYLE_NARROW, STYLE_EDGES, STYLE_MIN, STYLE_MAX}
    sample_style_t;

  typedef struct packed {
    row_kind_t             kind;
    logic signed [15:0]    value;  // sample, or window length for a register row
    logic                  last;
    logic                  typed;  // want holds a hand-written result
    swms_pkg::out_item_t   want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [25] = '{
    // window of one after reset
    '{ROW_SAMPLE, 16'sd5,     1'b1, 1'b1, '{26'sd5, 20'd0, 1'b0}},
    '{ROW_SAMPLE, 16'sh8000,  1'b1, 1'b1, '{-26'sd32768, 20'd0, 1'b0}},
    '{ROW_SAMPLE, 16'sd32767, 1'b1, 1'b1, '{26'sd32767, 20'd0, 1'b0}},
    // equal sums: the latest window wins
    '{ROW_SAMPLE, 16'sd3,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'sd3,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'sd3,     1'b1, 1'b1, '{26'sd3, 20'd2, 1'b0}},
    // window of three: a short stream, then a full one
    '{ROW_WINDOW, 16'sd3,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'sd1,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'sd2,     1'b1, 1'b1, '{26'sd3, 20'd0, 1'b1}},
    '{ROW_SAMPLE, 16'sd4,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, -16'sd1,    1'b0, 1'b0, '0},
    '{ROW_SAMPLE, -16'sd1,    1'b0, 1'b0, '0},
    '{ROW_SAMPLE, -16'sd1,    1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'sd2,     1'b1, 1'b0, '0},
    // zero length acts as one
    '{ROW_WINDOW, 16'sd0,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'sd7,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, -16'sd2,    1'b1, 1'b0, '0},
    // all-ones length acts as the maximum
    '{ROW_WINDOW, 16'sd2047,  1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'sd100,   1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'sd1,     1'b1, 1'b1, '{26'sd101, 20'd0, 1'b1}},
    // a register write drops the stream in progress
    '{ROW_WINDOW, 16'sd2,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'sd9,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 16'sd9,     1'b0, 1'b0, '0},
    '{ROW_WINDOW, 16'sd2,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, -16'sd4,    1'b1, 1'b1, '{-26'sd4, 20'd0, 1'b1}}
  };

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  swms_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  swms_pkg::out_item_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [swms_pkg::CFG_BITS-1:0] cfg_data = '0;

  // Hand-written result that travels with the current transaction
  logic                          typed_flag = 1'b0;
  swms_pkg::out_item_t           typed_result = '0;

  // Predictor state
  logic [swms_pkg::CFG_BITS-1:0] window_reg = 11'd1;
  longint                        hist_samples [WINDOW_DEPTH];
  int unsigned                   hist_pos = 0;
  longint                        acc_sum = 0;
  longint                        low_sum = 0;
  int unsigned                   low_start = 0;
  int unsigned                   seen_count = 0;

  swms_pkg::out_item_t           expected_minima [$];
  int                            error_count = 0;
  int                            samples_sent = 0;
  bit                            burst_mode = 1'b0;
  int                            ready_hold = 0;

  sliding_window_min_sum #(.WINDOW_MAX(WINDOW_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned effective_len();
    if (window_reg == '0) return 1;
    if (window_reg > WINDOW_DEPTH) return WINDOW_DEPTH;
    return 32'(window_reg);
  endfunction

  function automatic void restart_stream();
    hist_pos = 0;
    acc_sum = 0;
    low_sum = 0;
    low_start = 0;
    seen_count = 0;
  endfunction

  // Advance the window by one sample; returns 1 with the stream result on the last sample
  function automatic bit predict_min_window(input swms_pkg::in_item_t item,
                                            output swms_pkg::out_item_t res);
    longint      s;
    int unsigned len;
    int unsigned idx;
    int unsigned pos;
    s = longint'(item.sample);
    len = effective_len();
    idx = seen_count;
    pos = (hist_pos >= len) ? 0 : hist_pos;
    if (idx < len) begin
      acc_sum += s;
      if (idx == len - 1) begin
        low_sum = acc_sum;
        low_start = 0;
      end
    end else begin
      acc_sum += s - hist_samples[pos];
      if (acc_sum <= low_sum) begin
        low_sum = acc_sum;
        low_start = idx - len + 1;
      end
    end
    hist_samples[pos] = s;
    hist_pos = (pos + 1 >= len) ? 0 : pos + 1;
    if (seen_count < COUNT_MAX) seen_count++;
    res = '0;
    if (!item.is_last) return 1'b0;
    if (seen_count >= len) begin
      res.min_sum = low_sum[swms_pkg::SUM_OUT_BITS-1:0];
      res.best_start = low_start[swms_pkg::COUNT_BITS-1:0];
    end else begin
      res.min_sum = acc_sum[swms_pkg::SUM_OUT_BITS-1:0];
      res.too_short = 1'b1;
    end
    restart_stream();
    return 1'b1;
  endfunction

  // Track register writes, predict on input transactions, check output transactions
  always @(posedge clk) begin
    swms_pkg::out_item_t predicted;
    swms_pkg::out_item_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        window_reg = cfg_data;
        restart_stream();
      end
      if (in_valid && in_ready) begin
        if (predict_min_window(in_data, predicted))
          expected_minima.insert(expected_minima.size(),
                                 typed_flag ? typed_result : predicted);
      end
      if (out_valid && out_ready) begin
        if (expected_minima.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: min_sum=%0d best_start=%0d too_short=%0b",
                     out_data.min_sum, out_data.best_start, out_data.too_short);
        end else begin
          want = expected_minima.pop_front();
          if (out_data.min_sum !== want.min_sum || out_data.best_start !== want.best_start ||
              out_data.too_short !== want.too_short) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch: expected min_sum=%0d best_start=%0d too_short=%0b, %s",
                       want.min_sum, want.best_start, want.too_short,
                       $sformatf("got min_sum=%0d best_start=%0d too_short=%0b",
                                 out_data.min_sum, out_data.best_start, out_data.too_short));
          end
        end
      end
    end
  end

  // Result-side backpressure: mostly short stalls, a few long ones, some long open stretches
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      case ($urandom_range(0, 9))
        0: begin
          out_ready <= 1'b0;
          ready_hold <= $urandom_range(10, 60);
        end
        1, 2: begin
          out_ready <= 1'b0;
          ready_hold <= $urandom_range(1, 3);
        end
        3: begin
          out_ready <= 1'b1;
          ready_hold <= $urandom_range(50, 200);
        end
        default: begin
          out_ready <= 1'b1;
          ready_hold <= $urandom_range(1, 4);
        end
      endcase
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  function automatic int pick_gap();
    if (burst_mode) return 0;
    case ($urandom_range(0, 19))
      12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
      18: return $urandom_range(4, 12);
      19: return $urandom_range(20, 60);
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_sample(input sample_style_t style);
    int v;
    case (style)
      STYLE_NARROW: v = $urandom_range(0, 8) - 4;
      STYLE_MIN: v = -32768;
      STYLE_MAX: v = 32767;
      STYLE_EDGES: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          default: v = $urandom;
        endcase
      end
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [swms_pkg::CFG_BITS-1:0] pick_window_len();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 1;
      2: v = $urandom_range(WINDOW_DEPTH + 1, (1 << swms_pkg::CFG_BITS) - 1);
      3: v = $urandom_range(9, 64);
      default: v = $urandom_range(2, 8);
    endcase
    return v[swms_pkg::CFG_BITS-1:0];
  endfunction

  // Called at a falling edge; returns at a falling edge after the transaction
  task automatic send_sample(input swms_pkg::in_item_t item, input logic typed,
                             input swms_pkg::out_item_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    typed_flag <= typed;
    typed_result <= want;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream(input int count, input sample_style_t style, input bit close);
    swms_pkg::in_item_t item;
    for (int i = 0; i < count; i++) begin
      item.sample = pick_sample(style);
      item.is_last = close && (i == count - 1);
      send_sample(item, 1'b0, '0);
    end
  endtask

  // Hold the input off until every expected result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_minima.size() != 0);
  endtask

  task automatic set_window_len(input logic [swms_pkg::CFG_BITS-1:0] value);
    drain_results();
    // let a trailing sample that made no result clear the pipeline
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    swms_pkg::in_item_t item;
    int                 len;
    int                 count;
    int                 phase_end;
    sample_style_t      style;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].kind == ROW_WINDOW) begin
        set_window_len(DIRECTED_ROWS[r].value[swms_pkg::CFG_BITS-1:0]);
      end else begin
        item.sample = DIRECTED_ROWS[r].value;
        item.is_last = DIRECTED_ROWS[r].last;
        send_sample(item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end
    end
    drain_results();

    // Full windows of extreme samples with delay line wrap, then a clamped length
    set_window_len(11'd64);
    send_stream(64, STYLE_MIN, 1'b1);
    send_stream(66, STYLE_MAX, 1'b1);
    set_window_len(11'd1025);
    send_stream(40, STYLE_WIDE, 1'b1);

    // Random phases, each under its own window length
    samples_sent = 0;
    while (samples_sent < RANDOM_ITEMS) begin
      set_window_len(pick_window_len());
      burst_mode = ($urandom_range(0, 3) == 0);
      len = effective_len();
      phase_end = samples_sent + $urandom_range(30, 90);
      while (samples_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0: count = (len > 1) ? $urandom_range(1, (len - 1 < 30) ? len - 1 : 30) : 1;
          1: count = len;
          2: count = (len > 1) ? len - 1 : 1;
          default: count = len + $urandom_range(0, 2 * len + 6);
        endcase
        if (len > 64) count = $urandom_range(1, 30);
        case ($urandom_range(0, 2))
          0: style = STYLE_WIDE;
          1: style = STYLE_NARROW;
          default: style = STYLE_EDGES;
        endcase
        send_stream(count, style, 1'b1);
        if ($urandom_range(0, 19) == 0) drain_results();
      end
      // abandon a stream midway now and then; the next register write drops it
      if ($urandom_range(0, 3) == 0)
        send_stream($urandom_range(1, (len < 40) ? 2 * len : 40), STYLE_WIDE, 1'b0);
    end
    burst_mode = 1'b0;

    // Wait out the remaining results
    in_valid <= 1'b0;
    while (expected_minima.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/swms_pkg.sv
src/swms_front.sv
src/swms_fifo.sv
src/swms_back.sv
src/sliding_window_min_sum.sv
src/swms_checker.sv
dv/tb_sliding_window_min_sum.sv
